// ----- hdl/antialiased_shape_coverage_blend_top_defines.svh -----
// Assertion helpers used by the checker of this block.
`ifndef ANTIALIASED_SHAPE_COVERAGE_BLEND_TOP_DEFINES_SVH
`define ANTIALIASED_SHAPE_COVERAGE_BLEND_TOP_DEFINES_SVH

// Named concurrent assertion, sampled on the rising edge, off while reset is low.
`define ASCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Named assertion whose consequence must hold in the cycle after the condition.
`define ASCB_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- hdl/ascb_pkg.sv -----
package ascb_pkg;

    // Fixed-point layout of coordinates and coverage
    localparam int FRAC_BITS = 8;
    localparam int PIX_W     = 12;
    localparam int COORD_W   = PIX_W + FRAC_BITS + 1;
    localparam int RAD_W     = 16;
    localparam int SCALE_W   = 9;
    localparam int COLOR_W   = 32;
    localparam int CH_W      = 8;
    localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
    localparam int ONE_Q     = 1 << FRAC_BITS;

    // Geometry widths
    localparam int W_W    = COORD_W + 2;
    localparam int RD_W   = COORD_W + 3;
    localparam int PROD_W = 2 * W_W;
    localparam int DOT_W  = PROD_W + 1;
    localparam int LEN_W  = PROD_W;
    localparam int T_W    = FRAC_BITS + 1;
    localparam int VT_W   = W_W + T_W + 1;
    localparam int CD_W   = VT_W + 1;
    localparam int ABS_W  = COORD_W + 3;

    // Root and coverage widths
    localparam int SQ_W   = 2 * ABS_W + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int CV_W   = ROOT_W + 2;

    // Blend widths
    localparam int SCALE_FRAC = 8;
    localparam int A_W   = FRAC_BITS + SCALE_FRAC + 1;
    localparam int S_W   = A_W + CH_W;
    localparam int N_W   = S_W + CH_W + 1;
    localparam int Y_W   = N_W - (FRAC_BITS + SCALE_FRAC);
    localparam int Q_W   = CH_W + 2;
    localparam int ONE_A = 1 << (FRAC_BITS + SCALE_FRAC);
    localparam int CH_MAX = (1 << CH_W) - 1;
    localparam longint D_BLEND = longint'(CH_MAX) << (FRAC_BITS + SCALE_FRAC);
    localparam int RECIP_SHIFT = 2 * CH_W;
    localparam int RECIP_MUL   = (1 << CH_W) + 1;
    localparam int LANES = COLOR_W / CH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE_KIND     = 3'd0,
        CFG_CORNER_A_X     = 3'd1,
        CFG_CORNER_A_Y     = 3'd2,
        CFG_CORNER_B_X     = 3'd3,
        CFG_CORNER_B_Y     = 3'd4,
        CFG_RADIUS         = 3'd5,
        CFG_FILL_COLOR     = 3'd6,
        CFG_COVERAGE_SCALE = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic                      shape_kind;
        logic signed [COORD_W-1:0] corner_a_x;
        logic signed [COORD_W-1:0] corner_a_y;
        logic signed [COORD_W-1:0] corner_b_x;
        logic signed [COORD_W-1:0] corner_b_y;
        logic [RAD_W-1:0]          radius;
        logic [COLOR_W-1:0]        fill_color;
        logic [SCALE_W-1:0]        coverage_scale;
    } cfg_t;

endpackage

// ----- hdl/ascb_dist.sv -----
module ascb_dist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  ascb_pkg::cfg_t              cfg,
    input  logic                        in_valid,
    input  logic [ascb_pkg::PIX_W-1:0]  pixel_x,
    input  logic [ascb_pkg::PIX_W-1:0]  pixel_y,
    input  logic [ascb_pkg::COLOR_W-1:0] dest_in,
    output logic                        out_valid,
    output logic [ascb_pkg::ABS_W-1:0]  abs_dx,
    output logic [ascb_pkg::ABS_W-1:0]  abs_dy,
    output logic [ascb_pkg::COLOR_W-1:0] dest_out
);
    import ascb_pkg::*;

    // Shape constants from configuration
    logic signed [W_W-1:0] ax, ay, bx, by, rad_s, vx, vy;
    assign ax    = W_W'(cfg.corner_a_x);
    assign ay    = W_W'(cfg.corner_a_y);
    assign bx    = W_W'(cfg.corner_b_x);
    assign by    = W_W'(cfg.corner_b_y);
    assign rad_s = W_W'(cfg.radius);
    assign vx    = bx - ax;
    assign vy    = by - ay;

    // Stage 1: sample point, rectangle clamp, capsule offsets
    logic signed [W_W-1:0] px, py, lo_x, hi_x, lo_y, hi_y, cx, cy;
    assign px   = W_W'({pixel_x, FRAC_BITS'(HALF_Q)});
    assign py   = W_W'({pixel_y, FRAC_BITS'(HALF_Q)});
    assign lo_x = ax + rad_s;
    assign hi_x = bx - rad_s;
    assign lo_y = ay + rad_s;
    assign hi_y = by - rad_s;
    assign cx   = (px < lo_x) ? lo_x : ((hi_x < px) ? hi_x : px);
    assign cy   = (py < lo_y) ? lo_y : ((hi_y < py) ? hi_y : py);

    logic                   s1_valid_reg;
    logic signed [RD_W-1:0] s1_rdx_reg, s1_rdy_reg;
    logic signed [W_W-1:0]  s1_wx_reg, s1_wy_reg;
    logic [COLOR_W-1:0]     s1_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_rdx_reg  <= RD_W'(px) - RD_W'(cx);
            s1_rdy_reg  <= RD_W'(py) - RD_W'(cy);
            s1_wx_reg   <= px - ax;
            s1_wy_reg   <= py - ay;
            s1_dest_reg <= dest_in;
        end
    end

    // Stage 2: projection products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] s2_px_reg, s2_py_reg, s2_vxx_reg, s2_vyy_reg;
    logic signed [RD_W-1:0]   s2_rdx_reg, s2_rdy_reg;
    logic signed [W_W-1:0]    s2_wx_reg, s2_wy_reg;
    logic [COLOR_W-1:0]       s2_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_px_reg   <= s1_wx_reg * vx;
            s2_py_reg   <= s1_wy_reg * vy;
            s2_vxx_reg  <= vx * vx;
            s2_vyy_reg  <= vy * vy;
            s2_rdx_reg  <= s1_rdx_reg;
            s2_rdy_reg  <= s1_rdy_reg;
            s2_wx_reg   <= s1_wx_reg;
            s2_wy_reg   <= s1_wy_reg;
            s2_dest_reg <= s1_dest_reg;
        end
    end

    // Stage 3: dot product and squared length
    logic                    s3_valid_reg;
    logic signed [DOT_W-1:0] s3_dot_reg;
    logic [LEN_W-1:0]        s3_len_reg;
    logic signed [RD_W-1:0]  s3_rdx_reg, s3_rdy_reg;
    logic signed [W_W-1:0]   s3_wx_reg, s3_wy_reg;
    logic [COLOR_W-1:0]      s3_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dot_reg  <= DOT_W'(s2_px_reg) + DOT_W'(s2_py_reg);
            s3_len_reg  <= LEN_W'($unsigned(s2_vxx_reg)) + LEN_W'($unsigned(s2_vyy_reg));
            s3_rdx_reg  <= s2_rdx_reg;
            s3_rdy_reg  <= s2_rdy_reg;
            s3_wx_reg   <= s2_wx_reg;
            s3_wy_reg   <= s2_wy_reg;
            s3_dest_reg <= s2_dest_reg;
        end
    end

    // Divider stages: entry 0 sorts out the end cases, then one quotient bit each
    logic                   dv_valid_reg [0:FRAC_BITS];
    logic [LEN_W-1:0]       dv_rem_reg   [0:FRAC_BITS];
    logic [LEN_W-1:0]       dv_len_reg   [0:FRAC_BITS];
    logic [FRAC_BITS-1:0]   dv_q_reg     [0:FRAC_BITS];
    logic                   dv_zero_reg  [0:FRAC_BITS];
    logic                   dv_one_reg   [0:FRAC_BITS];
    logic signed [RD_W-1:0] dv_rdx_reg   [0:FRAC_BITS];
    logic signed [RD_W-1:0] dv_rdy_reg   [0:FRAC_BITS];
    logic signed [W_W-1:0]  dv_wx_reg    [0:FRAC_BITS];
    logic signed [W_W-1:0]  dv_wy_reg    [0:FRAC_BITS];
    logic [COLOR_W-1:0]     dv_dest_reg  [0:FRAC_BITS];

    logic t_zero, t_one;
    assign t_zero = (s3_len_reg == '0) || (s3_dot_reg <= 0);
    assign t_one  = !t_zero && (s3_dot_reg >= $signed({1'b0, s3_len_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]  <= LEN_W'(s3_dot_reg);
            dv_len_reg[0]  <= s3_len_reg;
            dv_q_reg[0]    <= '0;
            dv_zero_reg[0] <= t_zero;
            dv_one_reg[0]  <= t_one;
            dv_rdx_reg[0]  <= s3_rdx_reg;
            dv_rdy_reg[0]  <= s3_rdy_reg;
            dv_wx_reg[0]   <= s3_wx_reg;
            dv_wy_reg[0]   <= s3_wy_reg;
            dv_dest_reg[0] <= s3_dest_reg;
        end
    end

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_div
        logic [LEN_W:0] rem2;
        logic           ge;
        assign rem2 = {dv_rem_reg[k], 1'b0};
        assign ge   = rem2 >= {1'b0, dv_len_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[k+1]  <= ge ? LEN_W'(rem2 - {1'b0, dv_len_reg[k]}) : LEN_W'(rem2);
                dv_len_reg[k+1]  <= dv_len_reg[k];
                dv_q_reg[k+1]    <= {dv_q_reg[k][FRAC_BITS-2:0], ge};
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_one_reg[k+1]  <= dv_one_reg[k];
                dv_rdx_reg[k+1]  <= dv_rdx_reg[k];
                dv_rdy_reg[k+1]  <= dv_rdy_reg[k];
                dv_wx_reg[k+1]   <= dv_wx_reg[k];
                dv_wy_reg[k+1]   <= dv_wy_reg[k];
                dv_dest_reg[k+1] <= dv_dest_reg[k];
            end
        end
    end

    // Stage T: scale the direction by t
    logic [T_W-1:0]         t_val;
    logic signed [T_W:0]    t_s;
    assign t_val = dv_zero_reg[FRAC_BITS] ? '0 :
                   (dv_one_reg[FRAC_BITS] ? T_W'(ONE_Q) : T_W'(dv_q_reg[FRAC_BITS]));
    assign t_s   = $signed({1'b0, t_val});

    logic                   tm_valid_reg;
    logic signed [VT_W-1:0] tm_vxt_reg, tm_vyt_reg;
    logic signed [RD_W-1:0] tm_rdx_reg, tm_rdy_reg;
    logic signed [W_W-1:0]  tm_wx_reg, tm_wy_reg;
    logic [COLOR_W-1:0]     tm_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tm_valid_reg <= 1'b0;
        else if (en)
            tm_valid_reg <= dv_valid_reg[FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tm_vxt_reg  <= vx * t_s;
            tm_vyt_reg  <= vy * t_s;
            tm_rdx_reg  <= dv_rdx_reg[FRAC_BITS];
            tm_rdy_reg  <= dv_rdy_reg[FRAC_BITS];
            tm_wx_reg   <= dv_wx_reg[FRAC_BITS];
            tm_wy_reg   <= dv_wy_reg[FRAC_BITS];
            tm_dest_reg <= dv_dest_reg[FRAC_BITS];
        end
    end

    // Last stage: round the capsule offset, pick the shape, take magnitudes
    logic signed [CD_W-1:0]  cdx, cdy, sdx, sdy;
    logic signed [ABS_W:0]   dsx, dsy;
    assign cdx = (CD_W'(tm_wx_reg) <<< FRAC_BITS) - CD_W'(tm_vxt_reg) + CD_W'(HALF_Q);
    assign cdy = (CD_W'(tm_wy_reg) <<< FRAC_BITS) - CD_W'(tm_vyt_reg) + CD_W'(HALF_Q);
    assign sdx = cdx >>> FRAC_BITS;
    assign sdy = cdy >>> FRAC_BITS;
    assign dsx = cfg.shape_kind ? (ABS_W+1)'(sdx) : (ABS_W+1)'(tm_rdx_reg);
    assign dsy = cfg.shape_kind ? (ABS_W+1)'(sdy) : (ABS_W+1)'(tm_rdy_reg);

    logic               o_valid_reg;
    logic [ABS_W-1:0]   o_adx_reg, o_ady_reg;
    logic [COLOR_W-1:0] o_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= tm_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_adx_reg  <= dsx[ABS_W] ? ABS_W'(-dsx) : ABS_W'(dsx);
            o_ady_reg  <= dsy[ABS_W] ? ABS_W'(-dsy) : ABS_W'(dsy);
            o_dest_reg <= tm_dest_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign abs_dx    = o_adx_reg;
    assign abs_dy    = o_ady_reg;
    assign dest_out  = o_dest_reg;

endmodule

// ----- hdl/ascb_isqrt.sv -----
module ascb_isqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ascb_pkg::ABS_W-1:0]   abs_dx,
    input  logic [ascb_pkg::ABS_W-1:0]   abs_dy,
    input  logic [ascb_pkg::COLOR_W-1:0] dest_in,
    output logic                         out_valid,
    output logic [ascb_pkg::ROOT_W-1:0]  root,
    output logic [ascb_pkg::COLOR_W-1:0] dest_out
);
    import ascb_pkg::*;

    // Squares
    logic                 sq_valid_reg;
    logic [2*ABS_W-1:0]   sq_x_reg, sq_y_reg;
    logic [COLOR_W-1:0]   sq_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (en)
            sq_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg    <= abs_dx * abs_dx;
            sq_y_reg    <= abs_dy * abs_dy;
            sq_dest_reg <= dest_in;
        end
    end

    // Root stages: entry 0 holds the sum, then one root bit each
    logic                 it_valid_reg [0:ROOT_W];
    logic [SQ_W-1:0]      it_n_reg     [0:ROOT_W];
    logic [SQ_W-1:0]      it_r_reg     [0:ROOT_W];
    logic [COLOR_W-1:0]   it_dest_reg  [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            it_valid_reg[0] <= 1'b0;
        else if (en)
            it_valid_reg[0] <= sq_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_n_reg[0]    <= SQ_W'(sq_x_reg) + SQ_W'(sq_y_reg);
            it_r_reg[0]    <= '0;
            it_dest_reg[0] <= sq_dest_reg;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - k));
        logic [SQ_W-1:0] trial;
        logic            ge;
        assign trial = it_r_reg[k] + BIT;
        assign ge    = it_n_reg[k] >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                it_valid_reg[k+1] <= 1'b0;
            else if (en)
                it_valid_reg[k+1] <= it_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_n_reg[k+1]    <= ge ? it_n_reg[k] - trial : it_n_reg[k];
                it_r_reg[k+1]    <= ge ? (it_r_reg[k] >> 1) + BIT : it_r_reg[k] >> 1;
                it_dest_reg[k+1] <= it_dest_reg[k];
            end
        end
    end

    assign out_valid = it_valid_reg[ROOT_W];
    assign root      = it_r_reg[ROOT_W][ROOT_W-1:0];
    assign dest_out  = it_dest_reg[ROOT_W];

endmodule

// ----- hdl/ascb_blend.sv -----
module ascb_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  ascb_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    input  logic [ascb_pkg::ROOT_W-1:0]  root,
    input  logic [ascb_pkg::COLOR_W-1:0] dest_in,
    output logic                         out_valid,
    output logic [ascb_pkg::COLOR_W-1:0] out_pixel,
    output logic                         touched
);
    import ascb_pkg::*;

    function automatic logic [CH_W-1:0] s_dest_src(input logic [COLOR_W-1:0] word,
                                                    input int hi);
        s_dest_src = CH_W'(word >> (hi - CH_W + 1));
    endfunction

    // Stage 1: coverage from distance
    logic signed [CV_W-1:0] cov_raw;
    assign cov_raw = $signed(CV_W'(HALF_Q)) + $signed(CV_W'(cfg.radius))
                   - $signed(CV_W'(root));

    logic               c_valid_reg;
    logic [T_W-1:0]     c_cov_reg;
    logic [COLOR_W-1:0] c_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (cov_raw < 0)
                c_cov_reg <= '0;
            else if (cov_raw > $signed(CV_W'(ONE_Q)))
                c_cov_reg <= T_W'(ONE_Q);
            else
                c_cov_reg <= T_W'(cov_raw);
            c_dest_reg <= dest_in;
        end
    end

    // Stage 2: alpha, saturated at one
    logic [T_W+SCALE_W-1:0] a_prod;
    assign a_prod = c_cov_reg * cfg.coverage_scale;

    logic               a_valid_reg;
    logic [A_W-1:0]     a_val_reg;
    logic               a_touch_reg;
    logic [COLOR_W-1:0] a_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_val_reg   <= (a_prod > (T_W+SCALE_W)'(ONE_A)) ? A_W'(ONE_A) : A_W'(a_prod);
            a_touch_reg <= (a_prod != '0);
            a_dest_reg  <= c_dest_reg;
        end
    end

    // Stage 3: source weight
    logic               s_valid_reg;
    logic [S_W-1:0]     s_val_reg;
    logic               s_touch_reg;
    logic [COLOR_W-1:0] s_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else if (en)
            s_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_val_reg   <= a_val_reg * cfg.fill_color[CH_W-1:0];
            s_touch_reg <= a_touch_reg;
            s_dest_reg  <= a_dest_reg;
        end
    end

    // Stage 4: weighted sums per lane
    logic [S_W-1:0]  dst_w;
    assign dst_w = S_W'(D_BLEND) - s_val_reg;

    logic               n_valid_reg;
    logic [N_W-1:0]     n_val_reg [0:LANES-1];
    logic               n_touch_reg;
    logic [COLOR_W-1:0] n_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_valid_reg <= 1'b0;
        else if (en)
            n_valid_reg <= s_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_touch_reg <= s_touch_reg;
            n_dest_reg  <= s_dest_reg;
        end
    end

    // Side-band through stages 5 and 6
    logic               y_valid_reg, q_valid_reg;
    logic               y_touch_reg, q_touch_reg;
    logic [COLOR_W-1:0] y_dest_reg, q_dest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            y_valid_reg <= n_valid_reg;
            q_valid_reg <= y_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_touch_reg <= n_touch_reg;
            y_dest_reg  <= n_dest_reg;
            q_touch_reg <= y_touch_reg;
            q_dest_reg  <= y_dest_reg;
        end
    end

    // Output register
    logic               o_valid_reg;
    logic [COLOR_W-1:0] o_pix_reg;
    logic               o_touch_reg;

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        localparam int HI = COLOR_W - 1 - c * CH_W;
        logic [CH_W-1:0] src;
        logic [CH_W-1:0] dst;
        logic [Y_W-1:0]  y_sum;
        logic [Y_W+CH_W:0] y_mul;
        logic [Y_W-1:0]  y_rem;
        logic [Y_W-1:0]  y_reg;
        logic [Q_W-1:0]  q0_reg;
        logic [Q_W-1:0]  q_fix;
        logic [Y_W-1:0]  y5_reg;

        // The alpha lane blends full opacity as its source
        assign src = (c == LANES - 1) ? CH_W'(CH_MAX) : s_dest_src(cfg.fill_color, HI);
        assign dst = s_dest_reg[HI -: CH_W];

        always_ff @(posedge clk)
        begin
            if (en)
                n_val_reg[c] <= N_W'(src) * N_W'(s_val_reg) + N_W'(dst) * N_W'(dst_w);
        end

        // Stage 5: add half and drop the power-of-two part of the divisor
        assign y_sum = Y_W'((n_val_reg[c] + N_W'(D_BLEND / 2)) >> (FRAC_BITS + SCALE_FRAC));

        always_ff @(posedge clk)
        begin
            if (en)
                y5_reg <= y_sum;
        end

        // Stage 6: reciprocal estimate of the division by the channel maximum
        assign y_mul = y5_reg * (CH_W+1)'(RECIP_MUL);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                y_reg  <= y5_reg;
                q0_reg <= Q_W'(y_mul >> RECIP_SHIFT);
            end
        end

        // Stage 7: correct the estimate by one where it falls short
        assign y_rem = y_reg - Y_W'(q0_reg * CH_MAX);
        assign q_fix = (y_rem >= Y_W'(CH_MAX)) ? q0_reg + 1'b1 : q0_reg;

        always_ff @(posedge clk)
        begin
            if (en)
                o_pix_reg[HI -: CH_W] <= q_touch_reg ? q_fix[CH_W-1:0] : q_dest_reg[HI -: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= q_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            o_touch_reg <= q_touch_reg;
    end

    assign out_valid = o_valid_reg;
    assign out_pixel = o_pix_reg;
    assign touched   = o_touch_reg;

endmodule

// ----- hdl/antialiased_shape_coverage_blend_top.sv -----
// Anti-aliased shape fill: one pixel transaction per clock. Each pixel is sampled at its
// centre, its signed distance to the configured rounded rectangle or capsule turns into
// coverage, and the fill colour is blended source-over onto dest_pixel with per-channel
// rounding; a pixel with zero alpha comes back unchanged with touched low. The pipeline
// takes a new pixel every cycle unless stalled and passes each through 14 stages of
// geometry (of which 8 form the one-bit-per-stage capsule projection divider), 27 for
// the squared distance and its one-bit-per-stage integer square root, and 7 for alpha
// and the blend. All stages advance together; while a result sits on the output with
// out_stall high, the whole pipeline holds and in_stall is raised. Write configuration
// only while no pixel is in flight.
module antialiased_shape_coverage_blend_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ascb_pkg::PIX_W-1:0]      pixel_x,
    input  logic [ascb_pkg::PIX_W-1:0]      pixel_y,
    input  logic [ascb_pkg::COLOR_W-1:0]    dest_pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ascb_pkg::COLOR_W-1:0]    out_pixel,
    output logic                            touched,
    input  logic                            cfg_we,
    input  logic [ascb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ascb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ascb_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{coverage_scale: SCALE_W'(1 << SCALE_FRAC), default: '0};
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SHAPE_KIND:     cfg_reg.shape_kind     <= cfg_wdata[0];
                CFG_CORNER_A_X:     cfg_reg.corner_a_x     <= cfg_wdata[COORD_W-1:0];
                CFG_CORNER_A_Y:     cfg_reg.corner_a_y     <= cfg_wdata[COORD_W-1:0];
                CFG_CORNER_B_X:     cfg_reg.corner_b_x     <= cfg_wdata[COORD_W-1:0];
                CFG_CORNER_B_Y:     cfg_reg.corner_b_y     <= cfg_wdata[COORD_W-1:0];
                CFG_RADIUS:         cfg_reg.radius         <= cfg_wdata[RAD_W-1:0];
                CFG_FILL_COLOR:     cfg_reg.fill_color     <= cfg_wdata[COLOR_W-1:0];
                CFG_COVERAGE_SCALE: cfg_reg.coverage_scale <= cfg_wdata[SCALE_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Hold every stage while the output transaction waits
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic               g_valid;
    logic [ABS_W-1:0]   g_adx, g_ady;
    logic [COLOR_W-1:0] g_dest;

    ascb_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .dest_in   (dest_pixel),
        .out_valid (g_valid),
        .abs_dx    (g_adx),
        .abs_dy    (g_ady),
        .dest_out  (g_dest)
    );

    logic               r_valid;
    logic [ROOT_W-1:0]  r_root;
    logic [COLOR_W-1:0] r_dest;

    ascb_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .abs_dx    (g_adx),
        .abs_dy    (g_ady),
        .dest_in   (g_dest),
        .out_valid (r_valid),
        .root      (r_root),
        .dest_out  (r_dest)
    );

    ascb_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (r_valid),
        .root      (r_root),
        .dest_in   (r_dest),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .touched   (touched)
    );

endmodule

// ----- hdl/ascb_checker.sv -----
`include "antialiased_shape_coverage_blend_top_defines.svh"

module ascb_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ascb_pkg::COLOR_W-1:0] out_pixel,
    input logic                         touched
);
    import ascb_pkg::*;

    logic             out_held;
    logic [COLOR_W:0] out_word;
    assign out_held = out_valid && out_stall;
    assign out_word = {out_pixel, touched};

    // A stalled result keeps its value
    `ASCB_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_word), "held result changed")

    // Input stalls only behind a stalled output
    `ASCB_ASSERT(a_stall_cause, in_stall |-> out_held, "input stalled without output stall")

    // A stalled output holds the input too
    `ASCB_ASSERT(a_stall_back, out_held |-> in_stall, "output stall not passed back")

endmodule

bind antialiased_shape_coverage_blend_top ascb_checker u_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ascb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 400;

    typedef struct {
        logic [COLOR_W-1:0] pixel;
        logic               touched;
    } blend_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [PIX_W-1:0]      pixel_x;
    logic [PIX_W-1:0]      pixel_y;
    logic [COLOR_W-1:0]    dest_pixel;
    logic                  out_valid;
    logic                  out_stall;
    logic [COLOR_W-1:0]    out_pixel;
    logic                  touched;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Shadow copy of the shape and blend registers
    logic                      sh_kind;
    logic signed [COORD_W-1:0] sh_ax, sh_ay, sh_bx, sh_by;
    logic [RAD_W-1:0]          sh_radius;
    logic [COLOR_W-1:0]        sh_fill;
    logic [SCALE_W-1:0]        sh_scale;

    blend_result_t pending_pixels[$];
    int  mismatches;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  long_hold_req;
    int  hold_left;
    int  stall_left;
    int  quiet_cycles;

    antialiased_shape_coverage_blend_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_x(pixel_x), .pixel_y(pixel_y), .dest_pixel(dest_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_pixel(out_pixel), .touched(touched),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 clk = ~clk;

    // Floor integer square root
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Coverage from the offset to the closest core point
    function automatic longint coverage_of(longint dx, longint dy);
        longint ax;
        longint ay;
        longint radial;
        longint cov;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        radial = longint'(int_sqrt(longint'(ax * ax + ay * ay)));
        cov = HALF_Q - (radial - longint'(sh_radius));
        if (cov < 0)
            cov = 0;
        if (cov > ONE_Q)
            cov = ONE_Q;
        return cov;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (hi < v)
            return hi;
        return v;
    endfunction

    function automatic longint shape_coverage(longint px, longint py);
        longint vx, vy, wx, wy, len_sq, dot, t, dx, dy, cx, cy;
        if (!sh_kind)
        begin
            cx = clamp_to(px, longint'(sh_ax) + sh_radius, longint'(sh_bx) - sh_radius);
            cy = clamp_to(py, longint'(sh_ay) + sh_radius, longint'(sh_by) - sh_radius);
            return coverage_of(px - cx, py - cy);
        end
        vx = longint'(sh_bx) - longint'(sh_ax);
        vy = longint'(sh_by) - longint'(sh_ay);
        wx = px - longint'(sh_ax);
        wy = py - longint'(sh_ay);
        len_sq = vx * vx + vy * vy;
        dot = wx * vx + wy * vy;
        t = 0;
        if (len_sq != 0 && dot > 0)
            t = (dot >= len_sq) ? ONE_Q : (dot <<< FRAC_BITS) / len_sq;
        dx = (wx * ONE_Q - vx * t + HALF_Q) >>> FRAC_BITS;
        dy = (wy * ONE_Q - vy * t + HALF_Q) >>> FRAC_BITS;
        return coverage_of(dx, dy);
    endfunction

    function automatic longint unsigned blend_lane(longint unsigned src,
        longint unsigned dst, longint unsigned s, longint unsigned d);
        longint unsigned n;
        n = src * s + dst * (d - s);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic blend_result_t predict_blend(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
        logic [COLOR_W-1:0] dst);
        blend_result_t res;
        longint unsigned a, s, d;
        longint cov;
        cov = shape_coverage((longint'(x) <<< FRAC_BITS) + HALF_Q,
                             (longint'(y) <<< FRAC_BITS) + HALF_Q);
        a = longint'(cov) * sh_scale;
        if (a > ONE_A)
            a = ONE_A;
        if (a == 0)
        begin
            res.pixel = dst;
            res.touched = 1'b0;
            return res;
        end
        d = D_BLEND;
        s = a * sh_fill[7:0];
        res.pixel[31:24] = 8'(blend_lane(sh_fill[31:24], dst[31:24], s, d));
        res.pixel[23:16] = 8'(blend_lane(sh_fill[23:16], dst[23:16], s, d));
        res.pixel[15:8]  = 8'(blend_lane(sh_fill[15:8], dst[15:8], s, d));
        res.pixel[7:0]   = 8'(blend_lane(CH_MAX, dst[7:0], s, d));
        res.touched = 1'b1;
        return res;
    endfunction

    // Offer one pixel transaction, hold it until accepted, then queue its result
    task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic [COLOR_W-1:0] dst);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_x    <= x;
        pixel_y    <= y;
        dest_pixel <= dst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pixels.push_back(predict_blend(x, y, dst));
    endtask

    // Drop valid and wait until every queued result has arrived
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_SHAPE_KIND:     sh_kind   = data[0];
            CFG_CORNER_A_X:     sh_ax     = data[COORD_W-1:0];
            CFG_CORNER_A_Y:     sh_ay     = data[COORD_W-1:0];
            CFG_CORNER_B_X:     sh_bx     = data[COORD_W-1:0];
            CFG_CORNER_B_Y:     sh_by     = data[COORD_W-1:0];
            CFG_RADIUS:         sh_radius = data[RAD_W-1:0];
            CFG_FILL_COLOR:     sh_fill   = data;
            CFG_COVERAGE_SCALE: sh_scale  = data[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_shape(logic kind, int ax, int ay, int bx, int by, int rad,
        logic [COLOR_W-1:0] fill, int scale);
        wait_drained();
        write_reg(CFG_SHAPE_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_CORNER_A_X, ax);
        write_reg(CFG_CORNER_A_Y, ay);
        write_reg(CFG_CORNER_B_X, bx);
        write_reg(CFG_CORNER_B_Y, by);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_FILL_COLOR, fill);
        write_reg(CFG_COVERAGE_SCALE, scale);
    endtask

    // Random shape somewhere in the pixel plane, sometimes inverted
    task automatic random_shape();
        int cx, cy, w, h, scale;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        w = $urandom_range(0, 30);
        h = $urandom_range(0, 30);
        case ($urandom_range(0, 5))
            0: scale = 0;
            1: scale = $urandom_range(257, 511);
            2, 3: scale = 256;
            default: scale = $urandom_range(1, 255);
        endcase
        if ($urandom_range(0, 5) == 0)
            w = -w;
        set_shape(1'($urandom_range(0, 1)),
                  (cx - w) * 256 + $urandom_range(0, 255), (cy - h) * 256 + $urandom_range(0, 255),
                  (cx + w) * 256 + $urandom_range(0, 255), (cy + h) * 256 + $urandom_range(0, 255),
                  $urandom_range(0, 12 * 256), $urandom(), scale);
    endtask

    // Pixels mostly around the shape, some anywhere in the plane
    task automatic random_pixels(int count);
        int cx, cy, x, y;
        cx = (int'(sh_ax) + int'(sh_bx)) / 512;
        cy = (int'(sh_ay) + int'(sh_by)) / 512;
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end
            else
            begin
                x = cx + $urandom_range(0, 90) - 45;
                y = cy + $urandom_range(0, 90) - 45;
            end
            send_pixel(PIX_W'(x), PIX_W'(y), $urandom());
        end
    endtask

    task automatic test_reset_values();
        send_pixel(0, 0, 32'h1234_5678);
        send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_rect_cases();
        // Plain rounded rectangle: inside, on the edge, outside
        set_shape(1'b0, 10 * 256, 10 * 256, 20 * 256, 20 * 256, 3 * 256, 32'hFF80_40FF, 256);
        send_pixel(15, 15, 32'h0000_0000);
        send_pixel(10, 15, 32'hFFFF_FFFF);
        send_pixel(9, 9, 32'h8080_8080);
        send_pixel(30, 30, 32'hDEAD_BEEF);
        // Transparent fill still marks the pixel
        set_shape(1'b0, 10 * 256, 10 * 256, 20 * 256, 20 * 256, 0, 32'hFFFF_FF00, 256);
        send_pixel(15, 15, 32'hCAFE_F00D);
        // Zero scale leaves every pixel alone
        set_shape(1'b0, 10 * 256, 10 * 256, 20 * 256, 20 * 256, 0, 32'h1122_33FF, 0);
        send_pixel(15, 15, 32'hCAFE_F00D);
        // Scale above one saturates
        set_shape(1'b0, 10 * 256, 10 * 256, 20 * 256, 20 * 256, 256, 32'h1122_3380, 511);
        send_pixel(10, 15, 32'h5555_5555);
        send_pixel(15, 15, 32'hAAAA_AAAA);
        // Inverted rectangle in both axes
        set_shape(1'b0, 20 * 256, 20 * 256, 10 * 256, 10 * 256, 2 * 256, 32'h00FF_00C0, 200);
        send_pixel(5, 5, 32'h0F0F_0F0F);
        send_pixel(25, 25, 32'hF0F0_F0F0);
    endtask

    task automatic test_capsule_cases();
        // Circle: both ends equal
        set_shape(1'b1, 100 * 256, 100 * 256, 100 * 256, 100 * 256, 5 * 256, 32'hFF00_00FF, 256);
        send_pixel(100, 100, 32'h0000_00FF);
        send_pixel(104, 100, 32'h0000_00FF);
        send_pixel(99, 105, 32'h0000_00FF);
        // Thin segment
        set_shape(1'b1, 50 * 256, 60 * 256, 80 * 256, 71 * 256 + 77, 128, 32'h00FF_FFFF, 256);
        send_pixel(65, 65, 32'h1020_3040);
        send_pixel(49, 59, 32'h1020_3040);
        send_pixel(81, 72, 32'h1020_3040);
    endtask

    task automatic test_extremes();
        set_shape(1'b0, -1048576, -1048576, 1048575, 1048575, 65535, 32'hFFFF_FFFF, 511);
        send_pixel(0, 0, 32'h0000_0000);
        send_pixel(12'hFFF, 0, 32'h0000_0000);
        set_shape(1'b1, -1048576, 1048575, 1048575, -1048576, 65535, 32'h0000_0000, 256);
        send_pixel(0, 12'hFFF, 32'hFFFF_FFFF);
        send_pixel(2048, 2048, 32'h0000_0000);
    endtask

    task automatic test_random_shapes();
        repeat (10)
        begin
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en = $urandom_range(0, 3) != 0;
            random_shape();
            random_pixels(100);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering, then sender pauses
    task automatic test_backpressure();
        random_shape();
        long_hold_req = 1'b1;
        random_pixels(120);
        wait_drained();
        random_pixels(30);
    endtask

    task automatic test_full_rate();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_shape();
        random_pixels(100);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req <= 1'b0;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 12);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        blend_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pixel %h touched %b", out_pixel, touched);
            end
            else
            begin
                exp_res = pending_pixels.pop_front();
                if (out_pixel !== exp_res.pixel || touched !== exp_res.touched)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pixel %h touched %b, got pixel %h touched %b",
                                 exp_res.pixel, exp_res.touched, out_pixel, touched);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        dest_pixel = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SHAPE_KIND;
        cfg_wdata = '0;
        sh_kind = 1'b0;
        sh_ax = '0;
        sh_ay = '0;
        sh_bx = '0;
        sh_by = '0;
        sh_radius = '0;
        sh_fill = '0;
        sh_scale = 9'd256;
        mismatches = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        long_hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_rect_cases();
        test_capsule_cases();
        test_extremes();
        test_random_shapes();
        test_backpressure();
        test_full_rate();
        wait_drained();

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ascb_pkg.sv
hdl/ascb_dist.sv
hdl/ascb_isqrt.sv
hdl/ascb_blend.sv
hdl/antialiased_shape_coverage_blend_top.sv
hdl/ascb_checker.sv
test/testbench.sv
